// File: design/swing_door_segment_encoder_unit_macros.svh
// Assertion macros for the swing-door segment encoder unit.
`ifndef SWING_DOOR_SEGMENT_ENCODER_UNIT_MACROS_SVH
`define SWING_DOOR_SEGMENT_ENCODER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define SDSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdse: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define SDSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdse: next-cycle check failed");
`else
`define SDSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SDSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/sdse_pkg.sv
// Types and constants shared by the swing-door segment encoder.
package sdse_pkg;

    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 8;
    localparam int THR_W    = 15;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam logic [THR_W-1:0] THR_RESET = 15'd16;

    // Word index of the error threshold register (paddr[2]).
    localparam logic REG_ERR_THR = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_block;
    } in_beat_t;

    typedef struct packed {
        logic                       has_segment;
        logic [IDX_W-1:0]           start_index;
        logic [IDX_W-1:0]           end_index;
        logic signed [SAMPLE_W-1:0] start_value;
        logic signed [SAMPLE_W-1:0] slope;
        logic [IDX_W-1:0]           segment_count;
        logic                       too_long;
        logic                       last;
    } out_beat_t;

endpackage

// File: design/swing_door_segment_encoder_unit.sv
// Swing-door segment encoder: sample channel in, segment channel out, APB register.
//
// Samples enter on sample_valid/sample_stall, one beat per sample, with
// last_in_block on the final sample of a block. Segment beats leave on
// result_valid/result_stall from an output register; a block ends with a
// beat that has last set. The APB port holds error_threshold at address 0.
// Each sample that narrows the doors runs two divisions by the anchor
// distance on one shared restoring divider, one quotient bit per cycle.
// The quotients are MAG_W = clog2(65536*SLOPE_SCALE_FACTOR) bits wide (20 at
// the default scale). Such a sample passes through ST_DIV_HI, ST_DIV_LO and
// ST_DECIDE before the next sample beat is taken; a sample that closes a
// segment also passes ST_SEG, and the segment sits in the output register
// when the next sample is taken. First samples, ignored samples and samples
// past the segment limit stay in ST_IDLE, or go to ST_END if the block ends there.
// A sample that closes a segment and ends the block gives two beats.
// While the output register is held by result_stall, the block finishes
// its current sample and waits before writing the next beat. Reset
// clears the block state, opens the doors and sets error_threshold to 16.
`include "swing_door_segment_encoder_unit_macros.svh"

module swing_door_segment_encoder_unit #(
    parameter int SLOPE_SCALE_FACTOR = 16,
    parameter int BLOCK_LEN          = 128,
    parameter int MAX_SEGMENTS       = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  sdse_pkg::in_beat_t                sample_beat,
    output logic                              result_valid,
    input  logic                              result_stall,
    output sdse_pkg::out_beat_t               result_beat,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sdse_pkg::PADDR_W-1:0]      paddr,
    input  logic [sdse_pkg::PDATA_W-1:0]      pwdata,
    output logic [sdse_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int IDX_W  = sdse_pkg::IDX_W;
    localparam int SMP_W  = sdse_pkg::SAMPLE_W;
    localparam int THR_W  = sdse_pkg::THR_W;
    localparam int MAG_W  = $clog2(65536 * SLOPE_SCALE_FACTOR);
    localparam int NUM_W  = MAG_W + 1;
    localparam int POS_W  = $clog2(BLOCK_LEN + 1);
    localparam int DCNT_W = $clog2(MAG_W);

    localparam logic signed [NUM_W-1:0] SCALE = NUM_W'(SLOPE_SCALE_FACTOR);
    localparam logic signed [NUM_W-1:0] DOOR_UP_OPEN =
        NUM_W'(sdse_pkg::SAMPLE_MAX * SLOPE_SCALE_FACTOR);
    localparam logic signed [NUM_W-1:0] DOOR_LO_OPEN =
        NUM_W'(sdse_pkg::SAMPLE_MIN * SLOPE_SCALE_FACTOR);
    localparam logic signed [NUM_W:0] MID_MAX = (NUM_W+1)'(sdse_pkg::SAMPLE_MAX);
    localparam logic signed [NUM_W:0] MID_MIN = (NUM_W+1)'(sdse_pkg::SAMPLE_MIN);
    localparam logic [POS_W-1:0]  POS_FULL  = POS_W'(BLOCK_LEN);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(BLOCK_LEN - 1);
    localparam logic [IDX_W-1:0]  SEG_LIMIT = IDX_W'(MAX_SEGMENTS);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(MAG_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_HI,
        ST_DIV_LO,
        ST_DECIDE,
        ST_SEG,
        ST_END
    } state_t;

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [NUM_W-1:0] v);
        logic signed [NUM_W-1:0] a;
        a = v[NUM_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic signed [NUM_W-1:0] apply_sign(input logic [MAG_W-1:0] q,
                                                           input logic neg);
        logic signed [NUM_W-1:0] a;
        a = $signed({1'b0, q});
        return neg ? -a : a;
    endfunction

    state_t                    state_reg,        state_next;
    logic [THR_W-1:0]          thr_reg,          thr_next;
    logic [IDX_W-1:0]          anchor_index_reg, anchor_index_next;
    logic signed [SMP_W-1:0]   anchor_value_reg, anchor_value_next;
    logic signed [NUM_W-1:0]   upper_reg,        upper_next;
    logic signed [NUM_W-1:0]   lower_reg,        lower_next;
    logic [IDX_W-1:0]          segs_reg,         segs_next;
    logic [POS_W-1:0]          pos_reg,          pos_next;
    logic signed [SMP_W-1:0]   samp_reg,         samp_next;
    logic                      last_reg,         last_next;
    logic [IDX_W-1:0]          idx_reg,          idx_next;
    logic                      excess_reg,       excess_next;
    logic [IDX_W-1:0]          dt_reg,           dt_next;
    logic signed [NUM_W-1:0]   num_lo_reg,       num_lo_next;
    logic signed [NUM_W-1:0]   hi_reg,           hi_next;
    logic [MAG_W-1:0]          dq_reg,           dq_next;
    logic [IDX_W-1:0]          drem_reg,         drem_next;
    logic [DCNT_W-1:0]         dcnt_reg,         dcnt_next;
    logic                      dneg_reg,         dneg_next;
    logic                      out_valid_reg,    out_valid_next;
    sdse_pkg::out_beat_t       out_beat_reg,     out_beat_next;

    logic                      cfg_write;
    logic                      slot_free;
    logic                      take_sample;
    logic [IDX_W-1:0]          cur_idx;
    logic                      cur_excess;
    logic signed [SMP_W-1:0]   dy;
    logic signed [SMP_W+1:0]   sum_hi;
    logic signed [SMP_W+1:0]   sum_lo;
    logic signed [NUM_W-1:0]   num_hi;
    logic signed [NUM_W-1:0]   num_lo;
    logic [IDX_W:0]            rem_sh;
    logic [IDX_W:0]            rem_diff;
    logic                      q_bit;
    logic [IDX_W-1:0]          rem_new;
    logic [MAG_W-1:0]          q_new;
    logic signed [NUM_W-1:0]   lo_q;
    logic signed [NUM_W-1:0]   new_up;
    logic signed [NUM_W-1:0]   new_lo;
    logic signed [NUM_W:0]     door_sum;
    logic signed [NUM_W:0]     door_mid;
    logic signed [SMP_W-1:0]   mid_sat;
    logic                      div_busy;
    logic                      end_done;
    logic                      block_clear;

    // ---------------- register port ----------------
    assign cfg_write = psel && penable && pwrite && (paddr[2] == sdse_pkg::REG_ERR_THR);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == sdse_pkg::REG_ERR_THR) ?
                       sdse_pkg::PDATA_W'(thr_reg) : '0;
    assign thr_next  = cfg_write ? pwdata[THR_W-1:0] : thr_reg;

    // ---------------- handshakes ----------------
    assign sample_stall = (state_reg != ST_IDLE);
    assign take_sample  = sample_valid && (state_reg == ST_IDLE);
    assign slot_free    = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

    // ---------------- per-sample numerators ----------------
    assign cur_idx    = IDX_W'(pos_reg);
    assign cur_excess = (pos_reg == POS_FULL);
    assign dy         = sample_beat.sample - anchor_value_reg;
    assign sum_hi     = (SMP_W+2)'(dy) + $signed({3'b000, thr_reg});
    assign sum_lo     = (SMP_W+2)'(dy) - $signed({3'b000, thr_reg});
    assign num_hi     = NUM_W'(sum_hi) * SCALE;
    assign num_lo     = NUM_W'(sum_lo) * SCALE;

    // ---------------- restoring divider step ----------------
    assign rem_sh   = {drem_reg, dq_reg[MAG_W-1]};
    assign rem_diff = rem_sh - {1'b0, dt_reg};
    assign q_bit    = (rem_sh >= {1'b0, dt_reg});
    assign rem_new  = q_bit ? rem_diff[IDX_W-1:0] : rem_sh[IDX_W-1:0];
    assign q_new    = {dq_reg[MAG_W-2:0], q_bit};

    // ---------------- door update ----------------
    assign lo_q   = apply_sign(dq_reg, dneg_reg);
    assign new_up = (hi_reg < upper_reg) ? hi_reg : upper_reg;
    assign new_lo = (lo_q > lower_reg) ? lo_q : lower_reg;

    // Mid slope: halve toward zero, then clamp to 16 bits.
    assign door_sum = (NUM_W+1)'(upper_reg) + (NUM_W+1)'(lower_reg);
    assign door_mid = $signed(door_sum + (NUM_W+1)'(door_sum[NUM_W] & door_sum[0])) >>> 1;
    always_comb
    begin
        if (door_mid > MID_MAX)
        begin
            mid_sat = SMP_W'(sdse_pkg::SAMPLE_MAX);
        end
        else if (door_mid < MID_MIN)
        begin
            mid_sat = SMP_W'(sdse_pkg::SAMPLE_MIN);
        end
        else
        begin
            mid_sat = door_mid[SMP_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        logic [IDX_W-1:0] end_idx;
        end_idx = excess_reg ? IDX_LAST : idx_reg;

        state_next        = state_reg;
        anchor_index_next = anchor_index_reg;
        anchor_value_next = anchor_value_reg;
        upper_next        = upper_reg;
        lower_next        = lower_reg;
        segs_next         = segs_reg;
        pos_next          = pos_reg;
        samp_next         = samp_reg;
        last_next         = last_reg;
        idx_next          = idx_reg;
        excess_next       = excess_reg;
        dt_next           = dt_reg;
        num_lo_next       = num_lo_reg;
        hi_next           = hi_reg;
        dq_next           = dq_reg;
        drem_next         = drem_reg;
        dcnt_next         = dcnt_reg;
        dneg_next         = dneg_reg;
        out_beat_next     = out_beat_reg;
        out_valid_next    = out_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_sample)
                begin
                    samp_next   = sample_beat.sample;
                    last_next   = sample_beat.last_in_block;
                    idx_next    = cur_idx;
                    excess_next = cur_excess;
                    dt_next     = cur_idx - anchor_index_reg;
                    num_lo_next = num_lo;
                    dq_next     = magnitude(num_hi);
                    dneg_next   = num_hi[NUM_W-1];
                    drem_next   = '0;
                    dcnt_next   = '0;
                    if (cur_excess)
                    begin
                        state_next = sample_beat.last_in_block ? ST_END : ST_IDLE;
                    end
                    else if (pos_reg == '0)
                    begin
                        // first sample: anchor with open doors
                        anchor_index_next = '0;
                        anchor_value_next = sample_beat.sample;
                        upper_next        = DOOR_UP_OPEN;
                        lower_next        = DOOR_LO_OPEN;
                        pos_next          = pos_reg + 1'b1;
                        state_next        = sample_beat.last_in_block ? ST_END : ST_IDLE;
                    end
                    else if (segs_reg >= SEG_LIMIT)
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = sample_beat.last_in_block ? ST_END : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DIV_HI;
                    end
                end
            end
            ST_DIV_HI:
            begin
                dq_next   = q_new;
                drem_next = rem_new;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_LAST)
                begin
                    // hold upper quotient, load lower numerator
                    hi_next    = apply_sign(q_new, dneg_reg);
                    dq_next    = magnitude(num_lo_reg);
                    dneg_next  = num_lo_reg[NUM_W-1];
                    drem_next  = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIV_LO;
                end
            end
            ST_DIV_LO:
            begin
                dq_next   = q_new;
                drem_next = rem_new;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_LAST)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                pos_next = pos_reg + 1'b1;
                if (new_lo <= new_up)
                begin
                    upper_next = new_up;
                    lower_next = new_lo;
                    state_next = last_reg ? ST_END : ST_IDLE;
                end
                else
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_beat_next.has_segment   = 1'b1;
                    out_beat_next.start_index   = anchor_index_reg;
                    out_beat_next.end_index     = idx_reg - 1'b1;
                    out_beat_next.start_value   = anchor_value_reg;
                    out_beat_next.slope         = mid_sat;
                    out_beat_next.segment_count = segs_reg + 1'b1;
                    out_beat_next.too_long      = 1'b0;
                    out_beat_next.last          = 1'b0;
                    segs_next         = segs_reg + 1'b1;
                    anchor_index_next = idx_reg;
                    anchor_value_next = samp_reg;
                    upper_next        = DOOR_UP_OPEN;
                    lower_next        = DOOR_LO_OPEN;
                    state_next        = last_reg ? ST_END : ST_IDLE;
                end
            end
            ST_END:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_beat_next.too_long = excess_reg;
                    out_beat_next.last     = 1'b1;
                    if (segs_reg < SEG_LIMIT)
                    begin
                        out_beat_next.has_segment   = 1'b1;
                        out_beat_next.start_index   = anchor_index_reg;
                        out_beat_next.end_index     = end_idx;
                        out_beat_next.start_value   = anchor_value_reg;
                        out_beat_next.slope         = (end_idx == '0) ? '0 : mid_sat;
                        out_beat_next.segment_count = segs_reg + 1'b1;
                    end
                    else
                    begin
                        // segment limit reached: bare end marker
                        out_beat_next.has_segment   = 1'b0;
                        out_beat_next.start_index   = '0;
                        out_beat_next.end_index     = '0;
                        out_beat_next.start_value   = '0;
                        out_beat_next.slope         = '0;
                        out_beat_next.segment_count = segs_reg;
                    end
                    anchor_index_next = '0;
                    anchor_value_next = '0;
                    upper_next        = DOOR_UP_OPEN;
                    lower_next        = DOOR_LO_OPEN;
                    segs_next         = '0;
                    pos_next          = '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            thr_reg          <= sdse_pkg::THR_RESET;
            anchor_index_reg <= '0;
            anchor_value_reg <= '0;
            upper_reg        <= DOOR_UP_OPEN;
            lower_reg        <= DOOR_LO_OPEN;
            segs_reg         <= '0;
            pos_reg          <= '0;
            samp_reg         <= '0;
            last_reg         <= 1'b0;
            idx_reg          <= '0;
            excess_reg       <= 1'b0;
            dt_reg           <= '0;
            num_lo_reg       <= '0;
            hi_reg           <= '0;
            dq_reg           <= '0;
            drem_reg         <= '0;
            dcnt_reg         <= '0;
            dneg_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_beat_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            thr_reg          <= thr_next;
            anchor_index_reg <= anchor_index_next;
            anchor_value_reg <= anchor_value_next;
            upper_reg        <= upper_next;
            lower_reg        <= lower_next;
            segs_reg         <= segs_next;
            pos_reg          <= pos_next;
            samp_reg         <= samp_next;
            last_reg         <= last_next;
            idx_reg          <= idx_next;
            excess_reg       <= excess_next;
            dt_reg           <= dt_next;
            num_lo_reg       <= num_lo_next;
            hi_reg           <= hi_next;
            dq_reg           <= dq_next;
            drem_reg         <= drem_next;
            dcnt_reg         <= dcnt_next;
            dneg_reg         <= dneg_next;
            out_valid_reg    <= out_valid_next;
            out_beat_reg     <= out_beat_next;
        end
    end

    // ---------------- checks ----------------
    assign div_busy    = (state_reg == ST_DIV_HI) || (state_reg == ST_DIV_LO);
    assign end_done    = (state_reg == ST_END) && slot_free;
    assign block_clear = (segs_reg == '0) && (pos_reg == '0);

    `SDSE_ASSERT_NOW(a_doors_ordered, clk, rst_n, 1'b1, lower_reg <= upper_reg)
    `SDSE_ASSERT_NOW(a_seg_limit, clk, rst_n, 1'b1, segs_reg <= SEG_LIMIT)
    `SDSE_ASSERT_NOW(a_div_nonzero, clk, rst_n, div_busy, dt_reg != '0)
    `SDSE_ASSERT_NEXT(a_block_cleared, clk, rst_n, end_done, block_clear && out_valid_reg)

endmodule

// File: dv/sdse_checker.sv
// Checker for the swing-door segment encoder: predicts segment beats and compares them.
module sdse_checker #(
    parameter int SLOPE_SCALE_FACTOR = 16,
    parameter int BLOCK_LEN          = 128,
    parameter int MAX_SEGMENTS       = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    input  logic                              sample_stall,
    input  sdse_pkg::in_beat_t                sample_beat,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  sdse_pkg::out_beat_t               result_beat,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sdse_pkg::PADDR_W-1:0]      paddr,
    input  logic [sdse_pkg::PDATA_W-1:0]      pwdata,
    input  logic [sdse_pkg::PDATA_W-1:0]      prdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending,
    output int                                beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 30;
    localparam int THR_W       = sdse_pkg::THR_W;
    localparam int PDATA_W     = sdse_pkg::PDATA_W;

    sdse_pkg::out_beat_t     expected_segments[$];
    logic [THR_W-1:0]        err_thr;
    int                      anchor_index;
    logic signed [15:0]      anchor_value;
    int                      upper_door;
    int                      lower_door;
    int                      segs_done;
    int                      position;
    int                      mismatches = 0;
    int                      beats_seen = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void open_doors();
        upper_door = sdse_pkg::SAMPLE_MAX * SLOPE_SCALE_FACTOR;
        lower_door = sdse_pkg::SAMPLE_MIN * SLOPE_SCALE_FACTOR;
    endfunction

    function automatic void clear_block();
        anchor_index = 0;
        anchor_value = '0;
        open_doors();
        segs_done    = 0;
        position     = 0;
    endfunction

    // Mid-door slope, truncated toward zero and clamped to 16 bits.
    function automatic logic signed [15:0] mid_door();
        int m;
        m = (upper_door + lower_door) / 2;
        if (m > sdse_pkg::SAMPLE_MAX)
            m = sdse_pkg::SAMPLE_MAX;
        if (m < sdse_pkg::SAMPLE_MIN)
            m = sdse_pkg::SAMPLE_MIN;
        return 16'(m);
    endfunction

    function automatic sdse_pkg::out_beat_t segment_beat(input bit has, input int first,
                                               input int stop,
                                               input logic signed [15:0] value,
                                               input logic signed [15:0] slope, input int count,
                                               input bit over, input bit closing);
        sdse_pkg::out_beat_t b;
        b.has_segment   = has;
        b.start_index   = 8'(first);
        b.end_index     = 8'(stop);
        b.start_value   = value;
        b.slope         = slope;
        b.segment_count = 8'(count);
        b.too_long      = over;
        b.last          = closing;
        return b;
    endfunction

    task automatic predict_sample(input sdse_pkg::in_beat_t b);
        int                 idx_now;
        int                 end_idx;
        int                 dt;
        int                 dy;
        int                 th;
        int                 hi;
        int                 lo;
        int                 nu;
        int                 nl;
        bit                 excess;
        logic signed [15:0] dy16;
        logic signed [15:0] slope16;
        idx_now = position;
        excess  = idx_now >= BLOCK_LEN;
        if (!excess)
        begin
            if (idx_now == 0)
            begin
                anchor_index = 0;
                anchor_value = b.sample;
                open_doors();
            end
            else if (segs_done < MAX_SEGMENTS)
            begin
                dt   = idx_now - anchor_index;
                // dy wraps to 16 bits before widening
                dy16 = b.sample - anchor_value;
                dy   = dy16;
                th   = int'(err_thr);
                hi   = ((dy + th) * SLOPE_SCALE_FACTOR) / dt;
                lo   = ((dy - th) * SLOPE_SCALE_FACTOR) / dt;
                nu   = (hi < upper_door) ? hi : upper_door;
                nl   = (lo > lower_door) ? lo : lower_door;
                if (nl <= nu)
                begin
                    upper_door = nu;
                    lower_door = nl;
                end
                else
                begin
                    segs_done++;
                    expected_segments.push_back(segment_beat(1'b1, anchor_index, idx_now - 1,
                        anchor_value, mid_door(), segs_done, 1'b0, 1'b0));
                    anchor_index = idx_now;
                    anchor_value = b.sample;
                    open_doors();
                end
            end
            position = idx_now + 1;
        end
        if (b.last_in_block)
        begin
            end_idx = excess ? BLOCK_LEN - 1 : idx_now;
            if (segs_done < MAX_SEGMENTS)
            begin
                slope16 = (end_idx == 0) ? 16'sd0 : mid_door();
                segs_done++;
                expected_segments.push_back(segment_beat(1'b1, anchor_index, end_idx,
                    anchor_value, slope16, segs_done, excess, 1'b1));
            end
            else
                expected_segments.push_back(segment_beat(1'b0, 0, 0, 16'sd0, 16'sd0, segs_done,
                    excess, 1'b1));
            clear_block();
        end
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %0d expected %0d",
                                      beats_seen, name, got, want));
    endtask

    task automatic check_beat(input sdse_pkg::out_beat_t got);
        sdse_pkg::out_beat_t want;
        beats_seen++;
        if (expected_segments.size() == 0)
        begin
            report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
            return;
        end
        want = expected_segments.pop_front();
        compare_field("has_segment", got.has_segment, want.has_segment);
        compare_field("start_index", got.start_index, want.start_index);
        compare_field("end_index", got.end_index, want.end_index);
        compare_field("start_value", got.start_value, want.start_value);
        compare_field("slope", got.slope, want.slope);
        compare_field("segment_count", got.segment_count, want.segment_count);
        compare_field("too_long", got.too_long, want.too_long);
        compare_field("last", got.last, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_thr = sdse_pkg::THR_RESET;
            clear_block();
            expected_segments.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == sdse_pkg::REG_ERR_THR)
            begin
                if (pwrite)
                    err_thr = pwdata[THR_W-1:0];
                else if (prdata !== {{(PDATA_W-THR_W){1'b0}}, err_thr})
                    report_mismatch($sformatf("threshold readback: got %0d expected %0d",
                                              prdata, err_thr));
            end
            if (sample_valid && !sample_stall)
                predict_sample(sample_beat);
            if (result_valid && !result_stall)
                check_beat(result_beat);
        end
        fail_count    <= mismatches;
        pending       <= expected_segments.size();
        beats_checked <= beats_seen;
    end

endmodule

// File: dv/tb.sv
// Testbench top for the swing-door segment encoder: stimulus, threshold phases and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOPE_SCALE_FACTOR = 16;
    localparam int BLOCK_LEN          = 128;
    localparam int MAX_SEGMENTS       = 32;
    localparam int NUM_PHASES         = 7;
    localparam int PHASE_ITEMS        = 165;
    localparam int SETTLE_CYCLES      = 64;
    localparam int DRAIN_LIMIT        = 20000;
    localparam int CYCLE_LIMIT        = 500000;
    localparam int PADDR_W            = sdse_pkg::PADDR_W;
    localparam int PDATA_W            = sdse_pkg::PDATA_W;
    localparam logic [PADDR_W-1:0] THR_ADDR = {sdse_pkg::REG_ERR_THR, 2'b00};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    sdse_pkg::in_beat_t  sample_beat = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    sdse_pkg::out_beat_t result_beat;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  beats_checked;

    logic signed [15:0]  block_samples[$];
    bit                  tx_quiet = 1'b0;
    bit                  rx_quiet = 1'b0;
    int                  stall_left = 0;
    int                  samples_sent = 0;
    int                  blocks_sent = 0;
    int                  long_blocks = 0;
    int                  cycle_count = 0;

    swing_door_segment_encoder_unit #(
        .SLOPE_SCALE_FACTOR(SLOPE_SCALE_FACTOR),
        .BLOCK_LEN(BLOCK_LEN),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_beat(sample_beat),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_beat(result_beat),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    sdse_checker #(
        .SLOPE_SCALE_FACTOR(SLOPE_SCALE_FACTOR),
        .BLOCK_LEN(BLOCK_LEN),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_beat(sample_beat),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_beat(result_beat),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .fail_count(fail_count),
        .pending(pending),
        .beats_checked(beats_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: after each accepted beat, hold stall for a random number of valid cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                stall_left = rx_quiet ? 0 : $urandom_range(0, 7);
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                if (result_valid)
                    stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb failed");
        $finish;
    end

    task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= THR_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [15:0] value, input bit closing);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_beat  <= '{sample: value, last_in_block: closing};
        do @(posedge clk); while (sample_stall);
        samples_sent++;
    endtask

    task automatic run_block();
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        foreach (block_samples[k])
            send_sample(block_samples[k], k == block_samples.size() - 1);
        blocks_sent++;
        if (block_samples.size() > BLOCK_LEN)
            long_blocks++;
    endtask

    // Drop valid, drain every expected beat, then let the divider finish.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic build_block();
        int pick;
        int len;
        int base;
        int step;
        pick = $urandom_range(0, 99);
        block_samples.delete();
        if (pick < 6)
        begin
            // alternate swings so that, at low thresholds, a segment closes every second sample until the segment limit
            len = $urandom_range(66, 80);
            for (int k = 0; k < len; k++)
            begin
                base = $urandom_range(4000, 16000);
                block_samples.push_back(16'((k % 2 == 0) ? base : -base));
            end
        end
        else if (pick < 40)
        begin
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
                block_samples.push_back(16'($urandom_range(0, 65535)));
        end
        else
        begin
            len  = (pick < 43) ? $urandom_range(BLOCK_LEN - 1, BLOCK_LEN + 5)
                               : $urandom_range(1, 24);
            base = $urandom_range(0, 65535);
            step = int'($urandom_range(0, 400)) - 200;
            for (int k = 0; k < len; k++)
                block_samples.push_back(16'(base + step * k + int'($urandom_range(0, 16)) - 8));
        end
    endtask

    initial
    begin
        int thr_plan[NUM_PHASES];
        int phase_start;
        thr_plan = '{0, 32767, 1, 16, 200, 0, 0};
        thr_plan[5] = $urandom_range(2, 64);
        thr_plan[6] = $urandom_range(0, 32767);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks at the reset threshold.
        block_samples = '{-16'sd32768};
        run_block();
        block_samples = '{16'sd32767};
        run_block();
        // dy wraps across the full range
        block_samples = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd5};
        run_block();
        // the last sample closes a segment: two beats
        block_samples = '{16'sd100, 16'sd100, 16'sd30000};
        run_block();
        block_samples = '{-16'sd32768, 16'sd32767};
        run_block();
        block_samples = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7};
        run_block();
        block_samples = '{16'sh5555, 16'shAAAA, 16'sd0};
        run_block();
        wait_idle();

        foreach (thr_plan[p])
        begin
            apb_access(1'b1, PDATA_W'(thr_plan[p]));
            apb_access(1'b0, '0);
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_ITEMS)
            begin
                build_block();
                run_block();
            end
            wait_idle();
        end

        begin
            int drain;
            drain = 0;
            while (pending != 0 && drain < DRAIN_LIMIT)
            begin
                @(posedge clk);
                drain++;
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        $display("Ran %0d samples in %0d blocks (%0d over-long) under %0d threshold settings",
                 samples_sent, blocks_sent, long_blocks, NUM_PHASES + 1);
        $display("Compared %0d segment beats; %0d still outstanding", beats_checked, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/sdse_pkg.sv
design/swing_door_segment_encoder_unit.sv
dv/sdse_checker.sv
dv/tb.sv
